FILE: sv/tcw_pkg.sv
// Package for the text console write engine: geometry constants, command and
// register codes, payload structs and the controller/datapath interface types.
// No dependencies.
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLS    = 80;
  localparam int unsigned ROWS    = 30;
  localparam int unsigned CELLS   = COLS * ROWS;
  localparam int unsigned COL_W   = $clog2(COLS + 1);
  localparam int unsigned ROW_W   = $clog2(ROWS);
  localparam int unsigned LC_W    = $clog2(ROWS + 1);
  localparam int unsigned ADDR_W  = $clog2(CELLS);

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CODE_W-1:0]  SPACE_CODE       = 16'd32;
  localparam logic [CODE_W-1:0]  CR_CODE          = 16'd13;
  localparam logic [CODE_W-1:0]  LF_CODE          = 16'd10;
  localparam logic [COLOR_W-1:0] DEF_COLOR_RST    = 8'd15;
  localparam logic [TICK_W-1:0]  BLINK_PERIOD_RST = 16'd30;

  // Configuration register indexes (index 1, the cursor glyph, is used by the
  // display only and is not held here)
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD  = 2'd2;

  typedef enum logic [3:0] {
    CMD_PRINT    = 4'd0,
    CMD_RAW      = 4'd1,
    CMD_NEWLINE  = 4'd2,
    CMD_SETCUR   = 4'd3,
    CMD_CLRCELL  = 4'd4,
    CMD_CLRSCR   = 4'd5,
    CMD_SETCOLOR = 4'd6,
    CMD_DEFCOLOR = 4'd7,
    CMD_VISIBLE  = 4'd8,
    CMD_TICK     = 4'd9,
    CMD_READ     = 4'd10
  } cmd_e;

  typedef struct packed {
    logic [3:0]         command;
    logic [CODE_W-1:0]  code;
    logic [15:0]        repeat_count;
    logic [7:0]         col;
    logic [7:0]         row;
    logic [COLOR_W-1:0] color;
    logic               visible;
  } tcw_in_t;

  typedef struct packed {
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic [ROW_W-1:0]   top_line;
    logic [CODE_W-1:0]  cell_code;
    logic [COLOR_W-1:0] cell_color;
    logic               cursor_shown;
    logic               ignored;
  } tcw_out_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] color;
  } cell_t;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_CLRSCR,
    OP_NL,
    OP_FILL,
    OP_PUT,
    OP_RAW_LOAD,
    OP_CR,
    OP_SETCUR,
    OP_CLRCELL,
    OP_SETCOLOR,
    OP_DEFCOLOR,
    OP_VIS,
    OP_TICK,
    OP_READ
  } dp_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_FILL,
    ST_IDLE,
    ST_DECODE,
    ST_PRINT,
    ST_NL,
    ST_PUT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic   item_load;
    dp_op_e op;
    logic   out_load;
  } tcw_ctrl_t;

  typedef struct packed {
    logic [3:0] command;
    logic       lc_zero;
    logic       code_cr;
    logic       code_lf;
    logic       col_wrap;
    logic       rep_zero;
    logic       rep_last;
    logic       fill_last;
    logic       out_free;
  } tcw_stat_t;

endpackage

`default_nettype wire

FILE: sv/tcw_ctrl.sv
// Controller of the text console write engine: sequences each item through
// decode, new line, character write, row or screen fill and result stages.
// Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire tcw_stat_t stat_i,
  output tcw_ctrl_t      ctrl_o
);

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_INIT: begin
        state_d = ST_FILL;
        ret_d   = ST_IDLE;
      end
      ST_FILL: begin
        if (stat_i.fill_last) state_d = ret_q;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat_i.command)
          CMD_PRINT: begin
            if (stat_i.lc_zero) begin
              state_d = ST_NL;
              ret_d   = ST_PRINT;
            end else begin
              state_d = ST_PRINT;
            end
          end
          CMD_RAW:     state_d = stat_i.rep_zero ? ST_DONE : ST_PUT;
          CMD_NEWLINE: begin
            state_d = ST_NL;
            ret_d   = ST_DONE;
          end
          CMD_CLRSCR: begin
            state_d = ST_FILL;
            ret_d   = ST_DONE;
          end
          default:     state_d = ST_DONE;
        endcase
      end
      ST_PRINT: begin
        if (stat_i.code_cr) begin
          state_d = ST_DONE;
        end else if (stat_i.code_lf) begin
          state_d = ST_NL;
          ret_d   = ST_DONE;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_NL: state_d = ST_FILL;
      ST_PUT: begin
        if (stat_i.col_wrap) begin
          state_d = ST_NL;
          ret_d   = ST_PUT;
        end else if (stat_i.command == CMD_RAW && !stat_i.rep_last) begin
          state_d = ST_PUT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o       = 1'b0;
    ctrl_o.item_load = 1'b0;
    ctrl_o.op        = OP_NOP;
    ctrl_o.out_load  = 1'b0;
    unique case (state_q)
      ST_INIT: ctrl_o.op = OP_INIT;
      ST_FILL: ctrl_o.op = OP_FILL;
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        ctrl_o.item_load = in_valid_i;
      end
      ST_DECODE: begin
        unique case (stat_i.command)
          CMD_RAW:      ctrl_o.op = stat_i.rep_zero ? OP_NOP : OP_RAW_LOAD;
          CMD_SETCUR:   ctrl_o.op = OP_SETCUR;
          CMD_CLRCELL:  ctrl_o.op = OP_CLRCELL;
          CMD_CLRSCR:   ctrl_o.op = OP_CLRSCR;
          CMD_SETCOLOR: ctrl_o.op = OP_SETCOLOR;
          CMD_DEFCOLOR: ctrl_o.op = OP_DEFCOLOR;
          CMD_VISIBLE:  ctrl_o.op = OP_VIS;
          CMD_TICK:     ctrl_o.op = OP_TICK;
          CMD_READ:     ctrl_o.op = OP_READ;
          default:      ctrl_o.op = OP_NOP;
        endcase
      end
      ST_PRINT: ctrl_o.op = stat_i.code_cr ? OP_CR : OP_NOP;
      ST_NL:    ctrl_o.op = OP_NL;
      ST_PUT:   ctrl_o.op = stat_i.col_wrap ? OP_NOP : OP_PUT;
      ST_DONE:  ctrl_o.out_load = stat_i.out_free;
      default:  ctrl_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/tcw_dp.sv
// Datapath of the text console write engine: cell memory, cursor and ring
// state, blink timer, configuration registers and the result register.
// Depends on tcw_pkg.
`default_nettype none

module tcw_dp
  import tcw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tcw_in_t               in_data_i,
  input  wire tcw_ctrl_t             ctrl_i,
  output tcw_stat_t                  stat_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output tcw_out_t                   out_data_o
);

  // Configuration
  logic [COLOR_W-1:0] default_color_q;
  logic [TICK_W-1:0]  blink_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_color_q <= DEF_COLOR_RST;
      blink_period_q  <= BLINK_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEFAULT_COLOR: default_color_q <= cfg_wdata_i[COLOR_W-1:0];
        REG_BLINK_PERIOD:  blink_period_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Item register
  tcw_in_t item_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.item_load) item_q <= in_data_i;
  end

  // Console state
  logic [ROW_W-1:0]   head_q, head_d;
  logic [LC_W-1:0]    lc_q, lc_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic               cur_en_q, cur_en_d;
  logic               phase_q, phase_d;
  logic [TICK_W-1:0]  ticks_q, ticks_d;
  logic [15:0]        rep_q, rep_d;
  logic [ADDR_W-1:0]  fill_addr_q, fill_addr_d;
  logic [ADDR_W-1:0]  fill_end_q, fill_end_d;
  logic [COLOR_W-1:0] fill_color_q, fill_color_d;

  logic               in_range;
  logic               lc_full;
  logic [COL_W-1:0]   x_sel;
  logic [ROW_W-1:0]   vrow_sel;
  logic [ROW_W:0]     phys_sum;
  logic [ROW_W-1:0]   phys;
  logic [ADDR_W-1:0]  cell_addr;
  logic [ROW_W:0]     nl_sum;
  logic [ROW_W-1:0]   nl_phys;
  logic [ADDR_W-1:0]  nl_base;
  logic [ROW_W-1:0]   head_inc;
  logic [TICK_W-1:0]  tick_inc;

  assign in_range = (item_q.col < 8'(COLS)) && (item_q.row < 8'(ROWS));
  assign lc_full  = (lc_q == LC_W'(ROWS));

  // Visible row to physical cell address through the line ring
  assign x_sel    = (ctrl_i.op == OP_PUT) ? col_q : item_q.col[COL_W-1:0];
  assign vrow_sel = (ctrl_i.op == OP_PUT) ? row_q : item_q.row[ROW_W-1:0];
  assign phys_sum = {1'b0, head_q} + {1'b0, vrow_sel};
  assign phys     = (phys_sum >= (ROW_W+1)'(ROWS)) ?
                    ROW_W'(phys_sum - (ROW_W+1)'(ROWS)) : phys_sum[ROW_W-1:0];
  assign cell_addr = ADDR_W'(ADDR_W'(phys) * ADDR_W'(COLS)) + ADDR_W'(x_sel);

  // Line taken by a new line: next unused one, or the old top line on scroll
  assign nl_sum  = {1'b0, head_q} + {1'b0, lc_q[ROW_W-1:0]};
  assign nl_phys = lc_full ? head_q :
                   (nl_sum >= (ROW_W+1)'(ROWS)) ?
                   ROW_W'(nl_sum - (ROW_W+1)'(ROWS)) : nl_sum[ROW_W-1:0];
  assign nl_base  = ADDR_W'(ADDR_W'(nl_phys) * ADDR_W'(COLS));
  assign head_inc = (head_q == ROW_W'(ROWS - 1)) ? '0 : head_q + 1'b1;
  assign tick_inc = ticks_q + 1'b1;

  always_comb begin
    head_d       = head_q;
    lc_d         = lc_q;
    col_d        = col_q;
    row_d        = row_q;
    color_d      = color_q;
    cur_en_d     = cur_en_q;
    phase_d      = phase_q;
    ticks_d      = ticks_q;
    rep_d        = rep_q;
    fill_addr_d  = fill_addr_q;
    fill_end_d   = fill_end_q;
    fill_color_d = fill_color_q;
    unique case (ctrl_i.op)
      OP_INIT: begin
        fill_addr_d  = '0;
        fill_end_d   = ADDR_W'(CELLS - 1);
        fill_color_d = DEF_COLOR_RST;
      end
      OP_CLRSCR: begin
        fill_addr_d  = '0;
        fill_end_d   = ADDR_W'(CELLS - 1);
        fill_color_d = default_color_q;
        head_d       = '0;
        lc_d         = '0;
        col_d        = '0;
        row_d        = '0;
      end
      OP_NL: begin
        col_d        = '0;
        fill_addr_d  = nl_base;
        fill_end_d   = nl_base + ADDR_W'(COLS - 1);
        fill_color_d = default_color_q;
        if (lc_full) begin
          head_d = head_inc;
          row_d  = ROW_W'(ROWS - 1);
        end else begin
          row_d = lc_q[ROW_W-1:0];
          lc_d  = lc_q + 1'b1;
        end
      end
      OP_FILL:     fill_addr_d = fill_addr_q + 1'b1;
      OP_PUT: begin
        col_d = col_q + 1'b1;
        rep_d = rep_q - 1'b1;
      end
      OP_RAW_LOAD: rep_d = item_q.repeat_count;
      OP_CR:       col_d = '0;
      OP_SETCUR: begin
        col_d = (item_q.col >= 8'(COLS)) ? COL_W'(COLS - 1) : item_q.col[COL_W-1:0];
        row_d = (item_q.row >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : item_q.row[ROW_W-1:0];
      end
      OP_SETCOLOR: color_d = item_q.color;
      OP_DEFCOLOR: color_d = default_color_q;
      OP_VIS: begin
        cur_en_d = item_q.visible;
        phase_d  = 1'b1;
        ticks_d  = '0;
      end
      OP_TICK: begin
        if (cur_en_q) begin
          if (tick_inc >= blink_period_q) begin
            ticks_d = '0;
            phase_d = ~phase_q;
          end else begin
            ticks_d = tick_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      lc_q     <= '0;
      col_q    <= '0;
      row_q    <= '0;
      color_q  <= DEF_COLOR_RST;
      cur_en_q <= 1'b0;
      phase_q  <= 1'b1;
      ticks_q  <= '0;
    end else begin
      head_q   <= head_d;
      lc_q     <= lc_d;
      col_q    <= col_d;
      row_q    <= row_d;
      color_q  <= color_d;
      cur_en_q <= cur_en_d;
      phase_q  <= phase_d;
      ticks_q  <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q        <= rep_d;
    fill_addr_q  <= fill_addr_d;
    fill_end_q   <= fill_end_d;
    fill_color_q <= fill_color_d;
  end

  // Cell memory: one write and one registered read port
  cell_t             mem [CELLS];
  cell_t             rdata_q;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  cell_t             mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = '{code: SPACE_CODE, color: default_color_q};
    unique case (ctrl_i.op)
      OP_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr_q;
        mem_wdata = '{code: SPACE_CODE, color: fill_color_q};
      end
      OP_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = '{code: item_q.code, color: color_q};
      end
      OP_CLRCELL: mem_we = in_range;
      default: ;
    endcase
  end

  assign mem_re = (ctrl_i.op == OP_READ) && in_range;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem[cell_addr];
  end

  // Result register
  tcw_out_t out_q;
  logic     out_valid_q;
  logic     rd_hit;
  logic     cell_cmd;

  assign rd_hit   = (item_q.command == CMD_READ) && in_range;
  assign cell_cmd = (item_q.command == CMD_READ) || (item_q.command == CMD_CLRCELL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q.cursor_col   <= col_q;
      out_q.cursor_row   <= row_q;
      out_q.top_line     <= head_q;
      out_q.cell_code    <= rd_hit ? rdata_q.code : '0;
      out_q.cell_color   <= rd_hit ? rdata_q.color : '0;
      out_q.cursor_shown <= cur_en_q & phase_q;
      out_q.ignored      <= cell_cmd & ~in_range;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller
  assign stat_o.command   = item_q.command;
  assign stat_o.lc_zero   = (lc_q == '0);
  assign stat_o.code_cr   = (item_q.code == CR_CODE);
  assign stat_o.code_lf   = (item_q.code == LF_CODE);
  assign stat_o.col_wrap  = (col_q >= COL_W'(COLS));
  assign stat_o.rep_zero  = (item_q.repeat_count == '0);
  assign stat_o.rep_last  = (rep_q == 16'd1);
  assign stat_o.fill_last = (fill_addr_q == fill_end_q);
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

endmodule

`default_nettype wire

FILE: sv/text_console_write_engine_unit.sv
// A simple command passes through the decode and done states into the result register;
// the next item is taken once that register is free. A new line adds row setup plus an
// 80-cell fill through the single memory write port; raw repeat writes one character per
// cycle, with a new line at each wrap; clear screen fills all 2400 cells, one per cycle.
// Reset: control state clears at once, then a pass writes every cell to a space in the
// reset default color while in_ready_o stays low; config writes are taken meanwhile.
`default_nettype none

module text_console_write_engine_unit
  import tcw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire tcw_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output tcw_out_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  tcw_ctrl_t ctrl;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  tcw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous item still in work");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cursor_row < ROW_W'(ROWS)) &&
                    (out_data_o.top_line < ROW_W'(ROWS)) &&
                    (out_data_o.cursor_col <= COL_W'(COLS)))
    else $error("cursor or top line out of range");

  a_ignored_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ignored |->
      (out_data_o.cell_code == '0) && (out_data_o.cell_color == '0))
    else $error("ignored cell access returned data");
`endif

endmodule

`default_nettype wire
